@@ rtl/core/ktpa_pkg.sv @@
package ktpa_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int WINDOW_W    = 24;
    localparam int TIME_W      = 32;
    localparam int LEVEL_W     = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 8'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_AWAY = 8'd130;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;

    typedef enum logic [1:0] {
        MODE_INITIAL = 2'd0,
        MODE_PRESENT = 2'd1,
        MODE_AWAY    = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REPORT_NONE     = 2'd0,
        REPORT_PLACED   = 2'd1,
        REPORT_RETURNED = 2'd2,
        REPORT_TONE     = 2'd3
    } report_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_WEIGHT_THRESHOLD = 3'd0,
        REG_FIRST_IR_THRESHOLD   = 3'd1,
        REG_SECOND_IR_THRESHOLD  = 3'd2,
        REG_PLACE_WINDOW_MS      = 3'd3,
        REG_IR_ACTIVE_WINDOW_MS  = 3'd4,
        REG_ALARM_DURATION_MS    = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] key_weight_threshold;
        logic [SAMPLE_W-1:0] first_ir_threshold;
        logic [SAMPLE_W-1:0] second_ir_threshold;
        logic [WINDOW_W-1:0] place_window_ms;
        logic [WINDOW_W-1:0] ir_active_window_ms;
        logic [WINDOW_W-1:0] alarm_duration_ms;
    } poll_cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] pressure_sample;
        logic [SAMPLE_W-1:0] first_ir_sample;
        logic [SAMPLE_W-1:0] second_ir_sample;
        logic                button_level;
        logic [TIME_W-1:0]   now_ms;
    } poll_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic               tone_on;
        report_t            report_code;
        logic               button_report;
    } poll_result_t;

endpackage

@@ rtl/core/ktpa_poll.sv @@
module ktpa_poll
    import ktpa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  poll_cfg_t    cfg,
    input  poll_item_t   item,
    output poll_result_t result
);

    mode_t             mode_reg, mode_next;
    logic              tone_armed_reg, tone_armed_next;
    logic              placed_rep_reg, placed_rep_next;
    logic              return_rep_reg, return_rep_next;
    logic              prev_button_reg, prev_button_next;
    logic [TIME_W-1:0] first_ir_stamp_reg, first_ir_stamp_next;
    logic [TIME_W-1:0] tone_stamp_reg, tone_stamp_next;
    logic [LEVEL_W-1:0] red_reg, red_next;
    logic [LEVEL_W-1:0] green_reg, green_next;
    logic              tone_reg, tone_next;

    logic              ir1_hit, ir2_hit, on_tray, light, in_place, in_ir_window, tone_over;
    logic [TIME_W-1:0] since_ir, since_tone;
    report_t           report;
    logic              pressed;

    // branch decode of the key-away poll
    assign ir1_hit      = item.first_ir_sample > cfg.first_ir_threshold;
    assign ir2_hit      = item.second_ir_sample > cfg.second_ir_threshold;
    assign on_tray      = item.pressure_sample >= cfg.key_weight_threshold;
    assign light        = item.pressure_sample < cfg.key_weight_threshold;
    assign since_ir     = item.now_ms - first_ir_stamp_reg;
    assign since_tone   = item.now_ms - tone_stamp_reg;
    assign in_place     = since_ir < {8'd0, cfg.place_window_ms};
    assign in_ir_window = since_ir < {8'd0, cfg.ir_active_window_ms};
    assign tone_over    = since_tone > {8'd0, cfg.alarm_duration_ms};

    // next state
    always_comb
    begin
        mode_next           = mode_reg;
        tone_armed_next     = tone_armed_reg;
        placed_rep_next     = placed_rep_reg;
        return_rep_next     = return_rep_reg;
        prev_button_next    = prev_button_reg;
        first_ir_stamp_next = first_ir_stamp_reg;
        tone_stamp_next     = tone_stamp_reg;
        red_next            = red_reg;
        green_next          = green_reg;
        tone_next           = tone_reg;
        unique case (mode_reg)
            MODE_PRESENT:
            begin
                if (light)
                begin
                    red_next        = LEVEL_AWAY;
                    green_next      = LEVEL_OFF;
                    return_rep_next = 1'b0;
                    mode_next       = MODE_AWAY;
                end
            end
            MODE_AWAY:
            begin
                priority if (ir1_hit)
                begin
                    first_ir_stamp_next = item.now_ms;
                    tone_armed_next     = 1'b0;
                    placed_rep_next     = 1'b0;
                end
                else if (on_tray && in_place && !placed_rep_reg)
                begin
                    placed_rep_next = 1'b1;
                end
                else if (on_tray)
                begin
                    red_next            = LEVEL_OFF;
                    green_next          = LEVEL_FULL;
                    tone_next           = 1'b0;
                    return_rep_next     = 1'b1;
                    first_ir_stamp_next = '0;
                    mode_next           = MODE_PRESENT;
                end
                else if (ir2_hit && in_ir_window && !tone_armed_reg)
                begin
                    tone_stamp_next = item.now_ms;
                    tone_next       = 1'b1;
                    tone_armed_next = 1'b1;
                end
                else
                begin
                    // tone switches off once its duration is exceeded
                    tone_next = tone_reg && !tone_over;
                end
                prev_button_next = item.button_level;
            end
            default:
            begin
                // initial mode and the unused code
                red_next   = LEVEL_OFF;
                green_next = LEVEL_FULL;
                mode_next  = MODE_PRESENT;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        report  = REPORT_NONE;
        pressed = 1'b0;
        if (mode_reg == MODE_AWAY)
        begin
            priority if (ir1_hit)
            begin
                report = REPORT_NONE;
            end
            else if (on_tray && in_place && !placed_rep_reg)
            begin
                report = REPORT_PLACED;
            end
            else if (on_tray)
            begin
                report = return_rep_reg ? REPORT_NONE : REPORT_RETURNED;
            end
            else if (ir2_hit && in_ir_window && !tone_armed_reg)
            begin
                report = REPORT_TONE;
            end
            else
            begin
                report = REPORT_NONE;
            end
            pressed = item.button_level && !prev_button_reg;
        end
    end

    assign result.red_level     = red_next;
    assign result.green_level   = green_next;
    assign result.tone_on       = tone_next;
    assign result.report_code   = report;
    assign result.button_report = pressed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MODE_INITIAL;
            tone_armed_reg     <= 1'b0;
            placed_rep_reg     <= 1'b0;
            return_rep_reg     <= 1'b0;
            prev_button_reg    <= 1'b0;
            first_ir_stamp_reg <= '0;
            tone_stamp_reg     <= '0;
            red_reg            <= LEVEL_OFF;
            green_reg          <= LEVEL_OFF;
            tone_reg           <= 1'b0;
        end
        else if (step)
        begin
            mode_reg           <= mode_next;
            tone_armed_reg     <= tone_armed_next;
            placed_rep_reg     <= placed_rep_next;
            return_rep_reg     <= return_rep_next;
            prev_button_reg    <= prev_button_next;
            first_ir_stamp_reg <= first_ir_stamp_next;
            tone_stamp_reg     <= tone_stamp_next;
            red_reg            <= red_next;
            green_reg          <= green_next;
            tone_reg           <= tone_next;
        end
    end

endmodule

@@ rtl/core/key_tray_presence_alarm_fsm.sv @@
// key tray presence and tamper alarm controller, one sensor poll per transfer
//
// input channel (in_valid/in_ready): one poll carrying the pressure sample, both
// infrared samples, the button level and the current millisecond time
// output channel (out_valid/out_ready): one result per poll with the led drive
// levels, the tone state, a report code and a button-press flag
// configuration: cfg_write/cfg_index/cfg_data, taken at any edge with cfg_write
// high, unknown indexes ignored; the user must write only while no poll is in
// flight, which the block itself does not enforce
// poll path: a taken poll sits in the input register and is processed by the
// mode logic into the result register, which offers it on the output; a poll
// waits in the input register while the result register is held
// throughput: one poll per cycle while out_ready is high, set by the single
// combinational pass from the input register through the mode logic into the
// result register; a stall at the output holds the result register, the input
// register still takes one more poll, then in_ready drops until the result is taken
// reset: mode initial, flags and timestamps cleared, leds and tone off, and the
// thresholds and windows back to their defaults
module key_tray_presence_alarm_fsm
    import ktpa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // poll channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_W-1:0]    pressure_sample,
    input  logic [SAMPLE_W-1:0]    first_ir_sample,
    input  logic [SAMPLE_W-1:0]    second_ir_sample,
    input  logic                   button_level,
    input  logic [TIME_W-1:0]      now_ms,
    // result channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [LEVEL_W-1:0]     red_level,
    output logic [LEVEL_W-1:0]     green_level,
    output logic                   tone_on,
    output logic [1:0]             report_code,
    output logic                   button_report
);

    poll_cfg_t    cfg_reg;
    logic         in_valid_reg;
    poll_item_t   in_item_reg;
    logic         out_valid_reg;
    poll_result_t out_result_reg;
    poll_result_t step_result;
    logic         step;

    // configuration registers, masked to their widths
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_weight_threshold <= 10'd512;
            cfg_reg.first_ir_threshold   <= 10'd300;
            cfg_reg.second_ir_threshold  <= 10'd300;
            cfg_reg.place_window_ms      <= 24'd2000;
            cfg_reg.ir_active_window_ms  <= 24'd3000;
            cfg_reg.alarm_duration_ms    <= 24'd5000;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_KEY_WEIGHT_THRESHOLD: cfg_reg.key_weight_threshold <= cfg_data[SAMPLE_W-1:0];
                REG_FIRST_IR_THRESHOLD:   cfg_reg.first_ir_threshold   <= cfg_data[SAMPLE_W-1:0];
                REG_SECOND_IR_THRESHOLD:  cfg_reg.second_ir_threshold  <= cfg_data[SAMPLE_W-1:0];
                REG_PLACE_WINDOW_MS:      cfg_reg.place_window_ms      <= cfg_data;
                REG_IR_ACTIVE_WINDOW_MS:  cfg_reg.ir_active_window_ms  <= cfg_data;
                REG_ALARM_DURATION_MS:    cfg_reg.alarm_duration_ms    <= cfg_data;
                default:                  ; // write ignored
            endcase
        end
    end

    // the registered poll moves on when the result register is free or being emptied
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg.pressure_sample  <= pressure_sample;
            in_item_reg.first_ir_sample  <= first_ir_sample;
            in_item_reg.second_ir_sample <= second_ir_sample;
            in_item_reg.button_level     <= button_level;
            in_item_reg.now_ms           <= now_ms;
        end
    end

    // mode logic and its state, updated once per poll
    ktpa_poll u_poll (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cfg    (cfg_reg),
        .item   (in_item_reg),
        .result (step_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_result_reg <= step_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red_level     = out_result_reg.red_level;
    assign green_level   = out_result_reg.green_level;
    assign tone_on       = out_result_reg.tone_on;
    assign report_code   = out_result_reg.report_code;
    assign button_report = out_result_reg.button_report;

endmodule
